// File: design/sets_pkg.sv
`default_nettype none

package sets_pkg;

    localparam int DEF_READ_CHUNK = 64;
    localparam int DEF_PAGE_BYTES = 16;

    // page offsets and page limits: PAGE_BYTES is at most 127
    localparam int PG_W = 7;

    // reciprocal of the page size, used to split a start address into pages
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W = 25;

    typedef enum logic [2:0] {
        CMD_RD      = 3'd0,
        CMD_WR      = 3'd1,
        CMD_PROTECT = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_DONE    = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_READ      = 4'd1,
        PH_WR_ENABLE = 4'd2,
        PH_WR_WRITE  = 4'd3,
        PH_WR_WAIT   = 4'd4,
        PH_PR_ENABLE = 4'd5,
        PH_ER_ENABLE = 4'd6,
        PH_EP_WRITE  = 4'd7,
        PH_EP_WAIT   = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        TX_READ  = 3'd0,
        TX_WREN  = 3'd1,
        TX_WRITE = 3'd2,
        TX_RDSR  = 3'd3,
        TX_WRSR  = 3'd4,
        TX_ERASE = 3'd5
    } t_txn;

    typedef enum logic {
        KIND_TXN  = 1'b0,
        KIND_DONE = 1'b1
    } t_kind;

    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h6C;
    localparam logic [7:0] OP_WREN  = 8'h96;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h6E;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] start_addr;
        logic [15:0] byte_count;
        logic [7:0]  arg_byte;
        logic        bus_error;
        logic [7:0]  status_byte;
        logic [15:0] quot;
    } t_item;

    typedef struct packed {
        t_kind       out_kind;
        t_txn        txn_type;
        logic [7:0]  opcode;
        logic [15:0] txn_addr;
        logic [6:0]  txn_len;
        logic [15:0] buf_offset;
        logic [7:0]  protect_value;
        logic        success;
    } t_result;

endpackage

`default_nettype wire

// File: design/serial_eeprom_transfer_sequencer_unit.sv
// Serial EEPROM transfer sequencer.
// Input channel (i_in_valid / o_in_stall) carries start requests (read, write,
// protect, erase) and bus-done events with error flag and status byte. Output
// channel (o_out_valid / i_out_stall) carries the next bus transaction to issue
// or a job completion report; each input transaction gives zero or one result.
// Reads are chunked to READ_CHUNK bytes, writes are cut at PAGE_BYTES page
// boundaries with a write enable before each page and status polling after.
// A result passes from the input register through one step of the sequencer
// into the output register.
// Throughput: one input transaction per cycle while the output is not stalled,
// set by the update of the phase and address registers on every step.
// Reset clears the job state to idle and empties both registers.
// When the receiver stalls, the result holds in the output register, one more
// input transaction is taken into the input register, and o_in_stall rises
// until the output register drains.
`default_nettype none

module serial_eeprom_transfer_sequencer_unit import sets_pkg::*; #(
    parameter int READ_CHUNK = DEF_READ_CHUNK,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [15:0] i_start_addr,
    input  wire logic [15:0] i_byte_count,
    input  wire logic [7:0]  i_arg_byte,
    input  wire logic        i_bus_error,
    input  wire logic [7:0]  i_status_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_out_kind,
    output logic [2:0]       o_txn_type,
    output logic [7:0]       o_opcode,
    output logic [15:0]      o_txn_addr,
    output logic [6:0]       o_txn_len,
    output logic [15:0]      o_buf_offset,
    output logic [7:0]       o_protect_value,
    output logic             o_success
);

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / PAGE_BYTES);

    logic    r_in_valid;
    t_item   r_in, n_in;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free, step, in_accept;
    logic    res_valid;
    t_result res;
    logic [40:0] quot_prod;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign quot_prod = 41'(i_start_addr) * 41'(RECIP);

    always_comb begin
        n_in.cmd         = t_cmd'(i_cmd);
        n_in.start_addr  = i_start_addr;
        n_in.byte_count  = i_byte_count;
        n_in.arg_byte    = i_arg_byte;
        n_in.bus_error   = i_bus_error;
        n_in.status_byte = i_status_byte;
        n_in.quot        = quot_prod[RECIP_SHIFT +: 16];
    end

    sets_core #(
        .READ_CHUNK (READ_CHUNK),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (step) begin
                r_out_valid <= res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_in <= n_in;
        if (step && res_valid) r_out <= res;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out.out_kind;
    assign o_txn_type      = r_out.txn_type;
    assign o_opcode        = r_out.opcode;
    assign o_txn_addr      = r_out.txn_addr;
    assign o_txn_len       = r_out.txn_len;
    assign o_buf_offset    = r_out.buf_offset;
    assign o_protect_value = r_out.protect_value;
    assign o_success       = r_out.success;

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_DONE |->
            o_txn_type == TX_READ && o_opcode == 8'h00 && o_txn_len == 7'd0 &&
            o_txn_addr == 16'h0000 && o_buf_offset == 16'h0000)
        else $error("completion carries transaction fields");

    a_write_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_TXN && o_txn_type == TX_WRITE |->
            32'(o_txn_len) <= PAGE_BYTES)
        else $error("data write longer than a page");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in))
        else $error("input register changed while stalled");

    a_success_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_success |-> o_out_kind == KIND_DONE)
        else $error("success flag on a bus transaction");

endmodule

`default_nettype wire

// File: design/sets_core.sv
`default_nettype none

module sets_core import sets_pkg::*; #(
    parameter int READ_CHUNK = DEF_READ_CHUNK,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output logic         o_res_valid,
    output t_result      o_res
);

    localparam logic [15:0]     RD_LIM  = 16'(READ_CHUNK);
    localparam logic [PG_W-1:0] PG_SIZE = PG_W'(PAGE_BYTES);

    t_phase          r_phase, n_phase;
    logic [15:0]     r_cur_addr, n_cur_addr;
    logic [15:0]     r_bytes_left, n_bytes_left;
    logic [15:0]     r_offset, n_offset;
    logic [7:0]      r_saved_arg, n_saved_arg;
    logic [PG_W-1:0] r_page_off, n_page_off;

    logic [15:0]     st_len, rd_len, wr_lim, wr_len, data_len;
    logic [16:0]     addr_sum;
    logic [PG_W-1:0] page_sum, wr_page_next, start_page;
    logic [31:0]     qp;
    logic [16:0]     rem;
    logic            busy;

    assign busy     = i_item.status_byte[0];
    assign st_len   = (i_item.byte_count > RD_LIM) ? RD_LIM : i_item.byte_count;
    assign rd_len   = (r_bytes_left > RD_LIM) ? RD_LIM : r_bytes_left;
    assign wr_lim   = {{(16-PG_W){1'b0}}, PG_SIZE - r_page_off};
    assign wr_len   = (r_bytes_left > wr_lim) ? wr_lim : r_bytes_left;
    assign data_len = (r_phase == PH_WR_ENABLE) ? wr_len : rd_len;
    assign addr_sum = {1'b0, r_cur_addr} + {1'b0, data_len};
    assign page_sum = r_page_off + data_len[PG_W-1:0];

    // a wrapped address is below the length just written, so below the page size
    assign wr_page_next = addr_sum[16] ? addr_sum[PG_W-1:0] :
                          ((page_sum == PG_SIZE) ? '0 : page_sum);

    // quotient is exact or one low: one correction step
    assign qp  = 32'(i_item.quot) * 32'(PAGE_BYTES);
    assign rem = {1'b0, i_item.start_addr} - {1'b0, qp[15:0]};
    assign start_page = (rem >= 17'(PAGE_BYTES)) ? PG_W'(rem - 17'(PAGE_BYTES)) :
                                                   PG_W'(rem);

    always_comb begin
        n_phase = r_phase;
        unique case (i_item.cmd)
            CMD_RD:      n_phase = PH_READ;
            CMD_WR:      n_phase = PH_WR_ENABLE;
            CMD_PROTECT: n_phase = PH_PR_ENABLE;
            CMD_ERASE:   n_phase = PH_ER_ENABLE;
            CMD_DONE: begin
                if (r_phase != PH_IDLE) begin
                    if (i_item.bus_error) begin
                        n_phase = PH_IDLE;
                    end else begin
                        unique case (r_phase)
                            PH_READ: begin
                                if (r_bytes_left == '0) n_phase = PH_IDLE;
                            end
                            PH_WR_ENABLE: n_phase = PH_WR_WRITE;
                            PH_WR_WRITE:  n_phase = PH_WR_WAIT;
                            PH_EP_WRITE:  n_phase = PH_EP_WAIT;
                            PH_WR_WAIT: begin
                                if (!busy) begin
                                    n_phase = (r_bytes_left != '0) ? PH_WR_ENABLE : PH_IDLE;
                                end
                            end
                            PH_PR_ENABLE: n_phase = PH_EP_WRITE;
                            PH_ER_ENABLE: n_phase = PH_EP_WRITE;
                            PH_EP_WAIT: begin
                                if (!busy) n_phase = PH_IDLE;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res_valid  = 1'b0;
        o_res        = '0;
        n_cur_addr   = r_cur_addr;
        n_bytes_left = r_bytes_left;
        n_offset     = r_offset;
        n_saved_arg  = r_saved_arg;
        n_page_off   = r_page_off;
        unique case (i_item.cmd)
            CMD_RD: begin
                o_res_valid     = 1'b1;
                o_res.txn_type  = TX_READ;
                o_res.opcode    = OP_READ;
                o_res.txn_addr  = i_item.start_addr;
                o_res.txn_len   = st_len[6:0];
                n_cur_addr      = i_item.start_addr + st_len;
                n_bytes_left    = i_item.byte_count - st_len;
                n_offset        = st_len;
            end
            CMD_WR: begin
                o_res_valid     = 1'b1;
                o_res.txn_type  = TX_WREN;
                o_res.opcode    = OP_WREN;
                n_cur_addr      = i_item.start_addr;
                n_bytes_left    = i_item.byte_count;
                n_offset        = '0;
                n_page_off      = start_page;
            end
            CMD_PROTECT, CMD_ERASE: begin
                o_res_valid     = 1'b1;
                o_res.txn_type  = TX_WREN;
                o_res.opcode    = OP_WREN;
                n_saved_arg     = i_item.arg_byte;
            end
            CMD_DONE: begin
                if (r_phase != PH_IDLE) begin
                    o_res_valid = 1'b1;
                    if (i_item.bus_error) begin
                        o_res.out_kind = KIND_DONE;
                    end else begin
                        unique case (r_phase)
                            PH_READ, PH_WR_ENABLE: begin
                                if (r_phase == PH_READ && r_bytes_left == '0) begin
                                    o_res.out_kind = KIND_DONE;
                                    o_res.success  = 1'b1;
                                end else begin
                                    o_res.txn_type   = (r_phase == PH_READ) ? TX_READ : TX_WRITE;
                                    o_res.opcode     = (r_phase == PH_READ) ? OP_READ : OP_WRITE;
                                    o_res.txn_addr   = r_cur_addr;
                                    o_res.txn_len    = data_len[6:0];
                                    o_res.buf_offset = r_offset;
                                    n_cur_addr       = addr_sum[15:0];
                                    n_bytes_left     = r_bytes_left - data_len;
                                    n_offset         = r_offset + data_len;
                                    if (r_phase == PH_WR_ENABLE) n_page_off = wr_page_next;
                                end
                            end
                            PH_WR_WRITE, PH_EP_WRITE: begin
                                o_res.txn_type = TX_RDSR;
                                o_res.opcode   = OP_RDSR;
                            end
                            PH_WR_WAIT: begin
                                if (busy) begin
                                    o_res.txn_type = TX_RDSR;
                                    o_res.opcode   = OP_RDSR;
                                end else if (r_bytes_left != '0) begin
                                    o_res.txn_type = TX_WREN;
                                    o_res.opcode   = OP_WREN;
                                end else begin
                                    o_res.out_kind = KIND_DONE;
                                    o_res.success  = 1'b1;
                                end
                            end
                            PH_PR_ENABLE: begin
                                o_res.txn_type      = TX_WRSR;
                                o_res.opcode        = OP_WRSR;
                                o_res.protect_value = r_saved_arg;
                            end
                            PH_ER_ENABLE: begin
                                o_res.txn_type = TX_ERASE;
                                o_res.opcode   = r_saved_arg;
                            end
                            PH_EP_WAIT: begin
                                if (busy) begin
                                    o_res.txn_type = TX_RDSR;
                                    o_res.opcode   = OP_RDSR;
                                end else begin
                                    o_res.out_kind = KIND_DONE;
                                    o_res.success  = 1'b1;
                                end
                            end
                            default: o_res_valid = 1'b0;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cur_addr   <= '0;
            r_bytes_left <= '0;
            r_offset     <= '0;
            r_saved_arg  <= '0;
            r_page_off   <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cur_addr   <= n_cur_addr;
            r_bytes_left <= n_bytes_left;
            r_offset     <= n_offset;
            r_saved_arg  <= n_saved_arg;
            r_page_off   <= n_page_off;
        end
    end

endmodule

`default_nettype wire
